@@ src/tlb_fifo_page_translator_unit_assert.svh @@
// ============================================================================
// Assertion macros for the TLB FIFO page translator
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ============================================================================
`ifndef TLB_FIFO_PAGE_TRANSLATOR_UNIT_ASSERT_SVH
`define TLB_FIFO_PAGE_TRANSLATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tftu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TFTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tftu assertion failed");

`endif

@@ src/tftu_pkg.sv @@
// ============================================================================
// TLB FIFO page translator package
// Sizes, shared types and address helpers for the translator and its TLB row.
// ============================================================================
package tftu_pkg;

    // Configuration of the translator; PAGE_COUNT and FRAME_COUNT are powers of two.
    localparam int TLB_ENTRIES  = 16;
    localparam int PAGE_COUNT   = 256;
    localparam int FRAME_COUNT  = 128;
    localparam int OFFSET_WIDTH = 8;

    // Fixed field widths.
    localparam int VA_W      = 16;
    localparam int PA_W      = 15;
    localparam int OUT_DATA_W = ((PA_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // Derived widths.
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);

    typedef logic [PAGE_W-1:0]       t_page;
    typedef logic [FRAME_W-1:0]      t_frame;
    typedef logic [OFFSET_WIDTH-1:0] t_offset;
    typedef logic [VA_W-1:0]         t_vaddr;

    // One TLB entry as it moves from cell to cell.
    typedef struct packed {
        logic   valid;
        t_page  page;
        t_frame frame;
    } t_tlb_entry;

    // Control from the translator to the TLB row.
    typedef struct packed {
        t_page  look_page;
        logic   shift_en;
        logic   repoint_en;
        t_page  old_page;
        t_page  new_page;
        t_frame new_frame;
    } t_tlb_ctrl;

    // Status from the TLB row back to the translator.
    typedef struct packed {
        logic   hit;
        t_frame frame;
        logic   old_found;
    } t_tlb_stat;

    // Page number of a virtual address, wrapped to the page table size.
    function automatic t_page page_of(input t_vaddr va);
        return t_page'(va >> OFFSET_WIDTH);
    endfunction

    // Offset part of a virtual address.
    function automatic t_offset offset_of(input t_vaddr va);
        return t_offset'(va);
    endfunction

endpackage

@@ src/tftu_tlb_cell.sv @@
// ============================================================================
// TLB cell
// Holds one TLB entry; takes its neighbour's entry on a fill shift and
// renames its page in place when the page it maps is evicted.
// ============================================================================
module tftu_tlb_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tftu_pkg::t_tlb_ctrl  i_ctrl,
    input  tftu_pkg::t_tlb_entry i_entry,
    output tftu_pkg::t_tlb_entry o_entry,
    output logic                 o_match,
    output logic                 o_old_match
);

    logic           r_valid;
    tftu_pkg::t_page  r_page;
    tftu_pkg::t_frame r_frame;

    // Valid bit moves with the entry along the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift_en) begin
            r_valid <= i_entry.valid;
        end
    end

    // Entry payload: shifted in on a fill, renamed on an eviction.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_en) begin
            r_page  <= i_entry.page;
            r_frame <= i_entry.frame;
        end else if (i_ctrl.repoint_en && o_old_match) begin
            r_page <= i_ctrl.new_page;
        end
    end

    // Lookup and eviction compares.
    assign o_match     = r_valid && (r_page == i_ctrl.look_page);
    assign o_old_match = r_valid && (r_page == i_ctrl.old_page);

    assign o_entry = '{valid: r_valid, page: r_page, frame: r_frame};

endmodule

@@ src/tftu_tlb_row.sv @@
// ============================================================================
// TLB row
// A shift line of TLB cells: new entries enter at the head and the oldest
// falls off the tail, which gives FIFO replacement.
// ============================================================================
module tftu_tlb_row (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tftu_pkg::t_tlb_ctrl i_ctrl,
    output tftu_pkg::t_tlb_stat o_stat
);

    tftu_pkg::t_tlb_entry w_link [tftu_pkg::TLB_ENTRIES+1];
    logic [tftu_pkg::TLB_ENTRIES-1:0] w_match;
    logic [tftu_pkg::TLB_ENTRIES-1:0] w_old_match;
    tftu_pkg::t_frame                 w_frame;

    // The new entry feeds the head of the row.
    assign w_link[0] = '{valid: 1'b1, page: i_ctrl.new_page, frame: i_ctrl.new_frame};

    for (genvar g = 0; g < tftu_pkg::TLB_ENTRIES; g++) begin : g_cell
        tftu_tlb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_entry     (w_link[g]),
            .o_entry     (w_link[g+1]),
            .o_match     (w_match[g]),
            .o_old_match (w_old_match[g])
        );
    end

    // Entries are unique, so at most one cell matches and an OR picks its frame.
    always_comb begin
        w_frame = '0;
        for (int k = 0; k < tftu_pkg::TLB_ENTRIES; k++) begin
            w_frame = w_frame | (w_match[k] ? w_link[k+1].frame : '0);
        end
    end

    assign o_stat = '{hit: |w_match, frame: w_frame, old_found: |w_old_match};

endmodule

@@ src/tlb_fifo_page_translator_unit.sv @@
// ============================================================================
// TLB FIFO page translator
// Translates virtual addresses through a FIFO-refilled TLB and a page table
// that hands out physical frames in FIFO order.
// ============================================================================
// Usage:
// A virtual address word enters on the slave stream (tdata[15:0]). The upper
// bits select the page, the low OFFSET_WIDTH bits pass through as offset.
// One result word leaves on the master stream: tdata holds the physical
// address, tuser holds the TLB hit and page fault flags.
// Each word passes an accept step and a lookup step: the accept cycle reads
// the page table, its residency bits and the frame owner memory into
// registered read ports, the lookup step compares against the TLB cell row
// and commits all table updates. The result is valid in the cycle after the
// commit, and no new word is taken before the last one is committed.
// If the receiver stalls, the result stays in the output register and the
// lookup step of the following word waits until that register is free.
// Reset empties the TLB and marks every page non-resident; no clearing pass
// is needed, as the page frame and frame owner memories are only read for
// entries already written.
// ============================================================================
module tlb_fifo_page_translator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream: tdata = virtual_address[15:0].
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [tftu_pkg::VA_W-1:0]           i_s_axis_tdata,
    // Master stream: tdata = physical_address[14:0], zero pad[15].
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [tftu_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tuser = tlb_hit[0], page_fault[1].
    output logic [tftu_pkg::OUT_USER_W-1:0]     o_m_axis_tuser
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state r_state, n_state;

    // Word registers captured at accept.
    tftu_pkg::t_page   r_page;
    tftu_pkg::t_offset r_offset;

    // Memories and their registered read data.
    tftu_pkg::t_frame r_page_frame [tftu_pkg::PAGE_COUNT];
    tftu_pkg::t_page  r_frame_owner [tftu_pkg::FRAME_COUNT];
    tftu_pkg::t_frame r_pf_rd;
    tftu_pkg::t_page  r_fo_rd;
    logic             r_res_rd;

    // Residency bits and frame allocator.
    logic [tftu_pkg::PAGE_COUNT-1:0] r_resident;
    tftu_pkg::t_frame                r_next_frame;
    logic                            r_mem_full;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic [tftu_pkg::PA_W-1:0] r_pa, n_pa;
    logic                    r_hit, n_hit;
    logic                    r_fault, n_fault;

    tftu_pkg::t_tlb_ctrl w_ctrl;
    tftu_pkg::t_tlb_stat w_stat;

    logic             w_accept;
    logic             w_commit;
    logic             w_resident;
    logic             w_fault;
    logic             w_evict;
    logic             w_repointed;
    tftu_pkg::t_frame w_frame;

    // Handshake and decision logic of the lookup cycle.
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_commit   = (r_state == ST_LOOK) && (!r_out_valid || i_m_axis_tready);
    assign w_resident = r_res_rd;
    assign w_fault    = !w_stat.hit && !w_resident;
    assign w_evict    = w_fault && r_mem_full;
    assign w_repointed = w_evict && w_stat.old_found;

    always_comb begin
        if (w_stat.hit) begin
            w_frame = w_stat.frame;
        end else if (w_resident) begin
            w_frame = r_pf_rd;
        end else begin
            w_frame = r_next_frame;
        end
    end

    // Control to the TLB row.
    assign w_ctrl = '{
        look_page:  r_page,
        shift_en:   w_commit && !w_stat.hit && !w_repointed,
        repoint_en: w_commit && w_evict,
        old_page:   r_fo_rd,
        new_page:   r_page,
        new_frame:  w_frame
    };

    tftu_tlb_row u_tlb_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

    // Next state and output register values.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_pa        = r_pa;
        n_hit       = r_hit;
        n_fault     = r_fault;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_commit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_pa        = tftu_pkg::PA_W'({w_frame, r_offset});
                    n_hit       = w_stat.hit;
                    n_fault     = w_fault;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_pa    <= n_pa;
        r_hit   <= n_hit;
        r_fault <= n_fault;
    end

    // Capture the address split at accept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= tftu_pkg::page_of(i_s_axis_tdata);
            r_offset <= tftu_pkg::offset_of(i_s_axis_tdata);
        end
    end

    // Page frame memory and residency bit: read at accept, written on a fault.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pf_rd  <= r_page_frame[tftu_pkg::page_of(i_s_axis_tdata)];
            r_res_rd <= r_resident[tftu_pkg::page_of(i_s_axis_tdata)];
        end
        if (w_commit && w_fault) begin
            r_page_frame[r_page] <= r_next_frame;
        end
    end

    // Frame owner memory: the owner of the next frame is read ahead at accept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fo_rd <= r_frame_owner[r_next_frame];
        end
        if (w_commit && w_fault) begin
            r_frame_owner[r_next_frame] <= r_page;
        end
    end

    // Residency bits and FIFO frame allocator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resident   <= '0;
            r_next_frame <= '0;
            r_mem_full   <= 1'b0;
        end else if (w_commit && w_fault) begin
            if (w_evict) begin
                r_resident[r_fo_rd] <= 1'b0;
            end
            r_resident[r_page] <= 1'b1;
            if (r_next_frame == tftu_pkg::FRAME_W'(tftu_pkg::FRAME_COUNT - 1)) begin
                r_next_frame <= '0;
                r_mem_full   <= 1'b1;
            end else begin
                r_next_frame <= r_next_frame + 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = tftu_pkg::OUT_DATA_W'(r_pa);
    assign o_m_axis_tuser  = {r_fault, r_hit};

endmodule

@@ src/tftu_checker.sv @@
// ============================================================================
// TLB FIFO page translator checker
// Port-level assertions on the translator's streams, bound to the top level.
// ============================================================================
`include "tlb_fifo_page_translator_unit_assert.svh"

module tftu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [tftu_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [tftu_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    logic w_in_acc;
    logic w_in_acc_idle;
    logic w_both_flags;
    logic w_stall;
    logic [tftu_pkg::OUT_DATA_W+tftu_pkg::OUT_USER_W-1:0] w_word;

    assign w_in_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_acc_idle = w_in_acc && !o_m_axis_tvalid;
    assign w_both_flags  = o_m_axis_tuser[0] && o_m_axis_tuser[1];
    assign w_stall       = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_word        = {o_m_axis_tdata, o_m_axis_tuser};

    // A translation is never both a TLB hit and a page fault.
    `TFTU_ASSERT_NOW(a_hit_excl_fault, i_clk, i_rst_n, o_m_axis_tvalid, !w_both_flags)

    // The slave side closes for the lookup cycle after each accepted word.
    `TFTU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_s_axis_tready)

    // With the output register empty, an accepted word's result appears on the master stream without a stall.
    `TFTU_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_acc_idle, ##1 o_m_axis_tvalid)

    // A stalled result word holds its contents.
    `TFTU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_stall, o_m_axis_tvalid && $stable(w_word))

endmodule

bind tlb_fifo_page_translator_unit tftu_checker u_tftu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ verif/tb.sv @@
// ============================================================================
// Testbench for the TLB FIFO page translator
// Drives virtual address words on the slave stream and predicts every physical
// address with its hit and fault flags. The prediction keeps its own copy of
// the TLB, the page table and the frame owner map. Each returned word is
// checked field by field against the oldest prediction, under random gaps on
// both streams and one long receiver stall.
// ============================================================================
`timescale 1ns / 100ps

module tb;

    import tftu_pkg::*;

    // Bit positions of the flags in the result tuser.
    localparam int USER_HIT_BIT   = 0;
    localparam int USER_FAULT_BIT = 1;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_WORDS   = 900;
    localparam int HOT_PAGES      = 8;
    localparam int RECENT_DEPTH   = 48;

    // One predicted translation.
    typedef struct packed {
        logic [PA_W-1:0] phys_addr;
        logic            tlb_hit;
        logic            page_fault;
    } t_translation;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [VA_W-1:0]       s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    // Shadow copy of the translator state.
    t_page  shadow_tlb_page  [TLB_ENTRIES];
    t_frame shadow_tlb_frame [TLB_ENTRIES];
    logic   shadow_tlb_valid [TLB_ENTRIES];
    int     shadow_fill_slot;
    t_frame shadow_page_frame    [PAGE_COUNT];
    logic   shadow_page_resident [PAGE_COUNT];
    t_page  shadow_frame_owner   [FRAME_COUNT];
    t_frame shadow_next_frame;
    logic   shadow_memory_full;

    t_translation pending_translations[$];
    int           error_count = 0;
    int           idle_cycles = 0;

    // Traffic shaping shared between the stimulus and the receiver.
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int   rx_hold_req = 0;
    int   rx_hold_left = 0;
    int   rx_stall_left = 0;

    tlb_fifo_page_translator_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),           // virtual_address[15:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // physical_address[14:0], pad[15]
        .o_m_axis_tuser  (o_m_axis_tuser)     // tlb_hit[0], page_fault[1]
    );

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Clears the shadow state as reset clears the block.
    task automatic clear_shadow_state();
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            shadow_tlb_valid[i] = 1'b0;
            shadow_tlb_page[i]  = '0;
            shadow_tlb_frame[i] = '0;
        end
        for (int p = 0; p < PAGE_COUNT; p++) begin
            shadow_page_resident[p] = 1'b0;
            shadow_page_frame[p]    = '0;
        end
        for (int f = 0; f < FRAME_COUNT; f++)
            shadow_frame_owner[f] = '0;
        shadow_fill_slot   = 0;
        shadow_next_frame  = '0;
        shadow_memory_full = 1'b0;
    endtask

    // Translates one address and advances the shadow TLB and page table.
    function automatic t_translation translate_address(input t_vaddr va);
        t_translation res;
        t_page        page;
        t_page        evicted;
        t_offset      offset;
        t_frame       frame;
        logic         hit;
        logic         fault;
        logic         repointed;
        page      = t_page'(va >> OFFSET_WIDTH);
        offset    = va[OFFSET_WIDTH-1:0];
        frame     = '0;
        hit       = 1'b0;
        fault     = 1'b0;
        repointed = 1'b0;

        // The lowest valid matching entry wins.
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && shadow_tlb_valid[i] && shadow_tlb_page[i] == page) begin
                frame = shadow_tlb_frame[i];
                hit   = 1'b1;
            end
        end

        if (!hit) begin
            if (shadow_page_resident[page]) begin
                frame = shadow_page_frame[page];
            end else begin
                // Page fault: take the next frame, evicting its owner once memory is full.
                fault = 1'b1;
                frame = shadow_next_frame;
                if (shadow_memory_full) begin
                    evicted = shadow_frame_owner[frame];
                    shadow_page_resident[evicted] = 1'b0;
                    for (int i = 0; i < TLB_ENTRIES; i++) begin
                        if (shadow_tlb_valid[i] && shadow_tlb_page[i] == evicted) begin
                            shadow_tlb_page[i] = page;
                            repointed = 1'b1;
                        end
                    end
                end
                shadow_page_frame[page]    = frame;
                shadow_page_resident[page] = 1'b1;
                shadow_frame_owner[frame]  = page;
                if (frame == t_frame'(FRAME_COUNT - 1)) begin
                    shadow_next_frame  = '0;
                    shadow_memory_full = 1'b1;
                end else begin
                    shadow_next_frame = frame + 1'b1;
                end
            end
            // A miss that did not repoint an entry refills the TLB in FIFO order.
            if (!repointed) begin
                shadow_tlb_page[shadow_fill_slot]  = page;
                shadow_tlb_frame[shadow_fill_slot] = frame;
                shadow_tlb_valid[shadow_fill_slot] = 1'b1;
                shadow_fill_slot = (shadow_fill_slot == TLB_ENTRIES - 1) ? 0
                                                                         : shadow_fill_slot + 1;
            end
        end

        res.phys_addr  = PA_W'({frame, offset});
        res.tlb_hit    = hit;
        res.page_fault = fault;
        return res;
    endfunction

    // Offers one address word after an optional gap and waits for it to be taken.
    task automatic send_address(input t_vaddr va);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= va;
        @(posedge clk);
        while (!o_s_axis_tready) @(posedge clk);
    endtask

    // Prediction of each accepted address word.
    always @(posedge clk) begin
        if (rst_n && s_tvalid && o_s_axis_tready)
            pending_translations.push_back(translate_address(s_tdata));
    end

    // Comparison of each accepted result word with the oldest prediction.
    always @(posedge clk) begin
        t_translation exp_tr;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_translations.size() == 0) begin
                $display("%0t: result word with none expected: tdata %h tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                exp_tr = pending_translations.pop_front();
                if (o_m_axis_tdata != OUT_DATA_W'(exp_tr.phys_addr)) begin
                    $display("%0t: physical_address expected %h actual %h",
                             $time, OUT_DATA_W'(exp_tr.phys_addr), o_m_axis_tdata);
                    error_count++;
                end
                if (o_m_axis_tuser[USER_HIT_BIT] != exp_tr.tlb_hit) begin
                    $display("%0t: tlb_hit expected %b actual %b",
                             $time, exp_tr.tlb_hit, o_m_axis_tuser[USER_HIT_BIT]);
                    error_count++;
                end
                if (o_m_axis_tuser[USER_FAULT_BIT] != exp_tr.page_fault) begin
                    $display("%0t: page_fault expected %b actual %b",
                             $time, exp_tr.page_fault, o_m_axis_tuser[USER_FAULT_BIT]);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, steady stretches and the requested long hold.
    always @(posedge clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            rx_stall_left = pick_gap();
            m_tready <= (rx_stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither stream moves a word.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Field extremes, alternating bit patterns, and page 0 on an empty TLB,
    // which must fault rather than hit.
    task automatic test_extremes();
        send_address(16'h0000);
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'h8000);
        send_address(16'h7FFF);
        send_address(16'hAAAA);
        send_address(16'h5555);
    endtask

    // Enough new pages to wrap the TLB fill slot, then pages 0x00 and 0xFF, which
    // are resident but have dropped out of the TLB, and page 0x00 again as a hit.
    task automatic test_tlb_refill();
        for (int p = 1; p <= 12; p++)
            send_address(t_vaddr'({t_page'(p), t_offset'($urandom_range(0, 255))}));
        send_address(16'h0012);
        send_address(16'hFF34);
        send_address(16'h0056);
    endtask

    // The receiver holds off while words keep coming, so the input stalls.
    task automatic test_back_pressure();
        tx_steady   = 1'b1;
        rx_hold_req = 64;
        for (int n = 0; n < 12; n++)
            send_address(t_vaddr'($urandom_range(0, 16'hFFFF)));
        tx_steady = 1'b0;
    endtask

    // Mixed traffic: a small drifting hot set for TLB hits, recently used
    // pages for resident misses, and uniform pages that fill memory, wrap the
    // frame FIFO and evict pages still held in the TLB.
    task automatic test_random_traffic(input int count);
        t_page hot_set[HOT_PAGES];
        t_page recent_pages[$];
        t_page page;
        int    sel;
        for (int h = 0; h < HOT_PAGES; h++)
            hot_set[h] = t_page'($urandom_range(0, PAGE_COUNT - 1));
        for (int n = 0; n < count; n++) begin
            // Change the idling pattern now and then, sometimes to none at all.
            if (n % 100 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 49) == 0)
                hot_set[$urandom_range(0, HOT_PAGES - 1)] =
                    t_page'($urandom_range(0, PAGE_COUNT - 1));
            sel = $urandom_range(0, 99);
            if (sel < 40)
                page = hot_set[$urandom_range(0, HOT_PAGES - 1)];
            else if (sel < 55 && recent_pages.size() > 0)
                page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            else
                page = t_page'($urandom_range(0, PAGE_COUNT - 1));
            recent_pages.push_back(page);
            if (recent_pages.size() > RECENT_DEPTH)
                void'(recent_pages.pop_front());
            send_address(t_vaddr'({page, t_offset'($urandom_range(0, 255))}));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Test sequence and end of run.
    initial begin
        int waited;
        clear_shadow_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_tlb_refill();
        test_back_pressure();
        test_random_traffic(RANDOM_WORDS);

        @(posedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_translations.size() != 0 && waited < WATCHDOG_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_translations.size() != 0) begin
            $display("%0t: %0d expected result words never arrived",
                     $time, pending_translations.size());
            error_count++;
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/tftu_pkg.sv
src/tftu_tlb_cell.sv
src/tftu_tlb_row.sv
src/tlb_fifo_page_translator_unit.sv
src/tftu_checker.sv
verif/tb.sv
